// ===== hdl/csub_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csub_pkg
// Types, codes and schedule tables shared by the curve subdivision step.
// ----------------------------------------------------------------------------
package csub_pkg;

  // Register index of the scheme selection register.
  localparam logic REG_SCHEME_MODE = 1'b0;

  // Scheme codes held in the mode register.
  localparam logic SCHEME_BSPLINE   = 1'b0;
  localparam logic SCHEME_FOURPOINT = 1'b1;

  // Operand slots of one job: oldest window point, the two newer window
  // points and the point just taken.
  localparam int SLOT_W0 = 0;
  localparam int SLOT_A  = 1;
  localparam int SLOT_B  = 2;
  localparam int SLOT_P  = 3;
  localparam int NUM_SLOTS = 4;

  typedef enum logic [2:0] {
    KIND_FIRST,
    KIND_BSP_SECOND,
    KIND_FP_SECOND,
    KIND_BSP,
    KIND_FP
  } csub_kind_e;

  typedef enum logic [2:0] {
    OP_P,
    OP_B,
    OP_MID,
    OP_BSP,
    OP_FM_IN,
    OP_FM_END
  } csub_op_e;

  typedef struct packed {
    csub_kind_e kind;
    logic       fin;
    logic       reflect;
  } csub_job_t;

  // Number of refined points a job produces.
  function automatic logic [2:0] run_length(csub_kind_e kind, logic fin);
    logic [2:0] n;
    begin
      unique case (kind)
        KIND_FIRST:      n = 3'd1;
        KIND_BSP_SECOND: n = 3'd1;
        KIND_FP_SECOND:  n = 3'd2;
        KIND_BSP:        n = fin ? 3'd3 : 3'd2;
        KIND_FP:         n = fin ? 3'd4 : 3'd2;
        default:         n = 3'd1;
      endcase
      return n;
    end
  endfunction

  // Operation that yields result number idx of a job.
  function automatic csub_op_e run_op(csub_kind_e kind, logic fin, logic [1:0] idx);
    csub_op_e op;
    begin
      op = OP_P;
      unique case (kind)
        KIND_FIRST:      op = OP_P;
        KIND_BSP_SECOND: op = fin ? OP_P : OP_MID;
        KIND_FP_SECOND:  op = (idx == 2'd0) ? OP_MID : OP_P;
        KIND_BSP: begin
          case (idx)
            2'd0:    op = OP_BSP;
            2'd1:    op = OP_MID;
            default: op = OP_P;
          endcase
        end
        KIND_FP: begin
          case (idx)
            2'd0:    op = OP_FM_IN;
            2'd1:    op = OP_B;
            2'd2:    op = OP_FM_END;
            default: op = OP_P;
          endcase
        end
        default: op = OP_P;
      endcase
      return op;
    end
  endfunction

endpackage

// ===== hdl/csub_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csub_front
// Takes control points, keeps the three point window and the point count,
// classifies each point into a job and queues it for the back end.
// ----------------------------------------------------------------------------
module csub_front
  import csub_pkg::*;
#(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          scheme_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic                          final_point_i,
  output logic                          job_valid_o,
  output csub_job_t                     job_o,
  output logic signed [COORD_WIDTH-1:0] job_x_o [NUM_SLOTS],
  output logic signed [COORD_WIDTH-1:0] job_y_o [NUM_SLOTS],
  input  logic                          job_pop_i
);

  localparam int QDepth = 2;

  logic signed [COORD_WIDTH-1:0] win_x_q [3];
  logic signed [COORD_WIDTH-1:0] win_y_q [3];
  logic [1:0] seen_q, seen_d;

  // Job queue storage and pointers.
  csub_job_t                     qjob_q [QDepth];
  logic signed [COORD_WIDTH-1:0] qx_q   [QDepth][NUM_SLOTS];
  logic signed [COORD_WIDTH-1:0] qy_q   [QDepth][NUM_SLOTS];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;

  logic      accept;
  logic      push;
  csub_job_t new_job;

  assign in_stall_o = (cnt_q == 2'(QDepth));
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    new_job.fin     = final_point_i;
    new_job.reflect = (seen_q == 2'd2);
    new_job.kind    = KIND_FIRST;
    push            = accept;
    unique case (seen_q)
      2'd0: new_job.kind = KIND_FIRST;
      2'd1: begin
        if (scheme_i == SCHEME_FOURPOINT) begin
          new_job.kind = KIND_FP_SECOND;
          // A second point that does not end the curve has nothing final yet.
          push = accept && final_point_i;
        end else begin
          new_job.kind = KIND_BSP_SECOND;
        end
      end
      default: new_job.kind = (scheme_i == SCHEME_FOURPOINT) ? KIND_FP : KIND_BSP;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push && !job_pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && job_pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_comb begin
    seen_d = seen_q;
    if (final_point_i) begin
      seen_d = 2'd0;
    end else if (seen_q != 2'd3) begin
      seen_d = seen_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      seen_q   <= '0;
      for (int i = 0; i < 3; i++) begin
        win_x_q[i] <= '0;
        win_y_q[i] <= '0;
      end
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (job_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (accept) begin
        seen_q <= seen_d;
        if (final_point_i) begin
          for (int i = 0; i < 3; i++) begin
            win_x_q[i] <= '0;
            win_y_q[i] <= '0;
          end
        end else begin
          win_x_q[0] <= win_x_q[1];
          win_y_q[0] <= win_y_q[1];
          win_x_q[1] <= win_x_q[2];
          win_y_q[1] <= win_y_q[2];
          win_x_q[2] <= point_x_i;
          win_y_q[2] <= point_y_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      qjob_q[wr_ptr_q]          <= new_job;
      qx_q[wr_ptr_q][SLOT_W0]   <= win_x_q[0];
      qx_q[wr_ptr_q][SLOT_A]    <= win_x_q[1];
      qx_q[wr_ptr_q][SLOT_B]    <= win_x_q[2];
      qx_q[wr_ptr_q][SLOT_P]    <= point_x_i;
      qy_q[wr_ptr_q][SLOT_W0]   <= win_y_q[0];
      qy_q[wr_ptr_q][SLOT_A]    <= win_y_q[1];
      qy_q[wr_ptr_q][SLOT_B]    <= win_y_q[2];
      qy_q[wr_ptr_q][SLOT_P]    <= point_y_i;
    end
  end

  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = qjob_q[rd_ptr_q];
  assign job_x_o     = qx_q[rd_ptr_q];
  assign job_y_o     = qy_q[rd_ptr_q];

endmodule

// ===== hdl/csub_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csub_back
// Walks each queued job one refined point per cycle unless the output stalls,
// evaluates the mask and saturates the result into the output register.
// ----------------------------------------------------------------------------
module csub_back
  import csub_pkg::*;
#(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_valid_i,
  input  csub_job_t                     job_i,
  input  logic signed [COORD_WIDTH-1:0] job_x_i [NUM_SLOTS],
  input  logic signed [COORD_WIDTH-1:0] job_y_i [NUM_SLOTS],
  output logic                          job_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [COORD_WIDTH-1:0] out_x_o,
  output logic signed [COORD_WIDTH-1:0] out_y_o,
  output logic                          last_of_run_o,
  output logic                          curve_end_o
);

  // Five guard bits cover the largest four-point sum with a reflected end.
  localparam int EW = COORD_WIDTH + 5;

  function automatic logic signed [COORD_WIDTH-1:0] calc(
    csub_op_e                      op,
    logic signed [COORD_WIDTH-1:0] w0,
    logic signed [COORD_WIDTH-1:0] a,
    logic signed [COORD_WIDTH-1:0] b,
    logic signed [COORD_WIDTH-1:0] p,
    logic                          reflect
  );
    logic signed [EW-1:0] ew0, ea, eb, ep, z, r, s, q;
    begin
      ew0 = EW'(w0);
      ea  = EW'(a);
      eb  = EW'(b);
      ep  = EW'(p);
      z   = reflect ? ((ea <<< 1) - eb) : ew0;
      r   = (ep <<< 1) - eb;
      s   = '0;
      case (op)
        OP_P:   q = ep;
        OP_B:   q = eb;
        OP_MID: begin
          s = eb + ep;
          q = s >>> 1;
        end
        OP_BSP: begin
          s = ea + (eb <<< 2) + (eb <<< 1) + ep;
          q = s >>> 3;
        end
        OP_FM_IN: begin
          s = (ea <<< 3) + ea + (eb <<< 3) + eb - z - ep;
          q = s >>> 4;
        end
        OP_FM_END: begin
          s = (eb <<< 3) + eb + (ep <<< 3) + ep - ea - r;
          q = s >>> 4;
        end
        default: q = ep;
      endcase
      if (q[EW-1:COORD_WIDTH-1] == {(EW-COORD_WIDTH+1){q[EW-1]}}) begin
        return q[COORD_WIDTH-1:0];
      end else if (q[EW-1]) begin
        return {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end else begin
        return {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end
    end
  endfunction

  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic       load;
  logic       last;
  csub_op_e   op;
  logic [2:0] len;

  logic signed [COORD_WIDTH-1:0] x_q, y_q;
  logic                          last_q, end_q;

  assign op   = run_op(job_i.kind, job_i.fin, idx_q);
  assign len  = run_length(job_i.kind, job_i.fin);
  assign last = ({1'b0, idx_q} == (len - 3'd1));

  // The output register takes a new point when it is empty or being drained.
  assign load      = job_valid_i && (!valid_q || !out_stall_i);
  assign job_pop_o = load && last;

  always_comb begin
    idx_d = idx_q;
    if (load) begin
      idx_d = last ? 2'd0 : idx_q + 2'd1;
    end
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      x_q    <= calc(op, job_x_i[SLOT_W0], job_x_i[SLOT_A], job_x_i[SLOT_B],
                     job_x_i[SLOT_P], job_i.reflect);
      y_q    <= calc(op, job_y_i[SLOT_W0], job_y_i[SLOT_A], job_y_i[SLOT_B],
                     job_y_i[SLOT_P], job_i.reflect);
      last_q <= last;
      end_q  <= last && job_i.fin;
    end
  end

  assign out_valid_o   = valid_q;
  assign out_x_o       = x_q;
  assign out_y_o       = y_q;
  assign last_of_run_o = last_q;
  assign curve_end_o   = end_q;

endmodule

// ===== hdl/curve_subdivision_step_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// curve_subdivision_step_top
// One level of open-curve subdivision (cubic B-spline or four-point) on a
// stream of signed fixed-point control points.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  input     in         in_valid_i/in_stall_o  point_x_i, point_y_i, final_point_i
//  output    out        out_valid_o/out_stall_i out_x_o, out_y_o, last_of_run_o,
//                                              curve_end_o
//  config    in         APB psel/penable       scheme_mode at byte address 0
//
// A point is accepted in any cycle the two-entry job queue has room.
// Results leave at one per cycle through a single output register while
// out_stall_i is low; an interior point gives two results, a final one up to four.
// Reset clears the window, the point count, the queue and the mode; no
// clearing pass is needed. A stalled output only holds the input side once
// the job queue is full.
// ----------------------------------------------------------------------------
module curve_subdivision_step_top
  import csub_pkg::*;
#(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic                          final_point_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [COORD_WIDTH-1:0] out_x_o,
  output logic signed [COORD_WIDTH-1:0] out_y_o,
  output logic                          last_of_run_o,
  output logic                          curve_end_o
);

  logic mode_q;
  logic cfg_write;

  logic                          job_valid;
  csub_job_t                     job;
  logic signed [COORD_WIDTH-1:0] job_x [NUM_SLOTS];
  logic signed [COORD_WIDTH-1:0] job_y [NUM_SLOTS];
  logic                          job_pop;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= SCHEME_BSPLINE;
    end else if (cfg_write && (paddr[2] == REG_SCHEME_MODE)) begin
      mode_q <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_SCHEME_MODE) ? {31'd0, mode_q} : 32'd0;

  csub_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .scheme_i     (mode_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .final_point_i(final_point_i),
    .job_valid_o  (job_valid),
    .job_o        (job),
    .job_x_o      (job_x),
    .job_y_o      (job_y),
    .job_pop_i    (job_pop)
  );

  csub_back #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (job_valid),
    .job_i        (job),
    .job_x_i      (job_x),
    .job_y_i      (job_y),
    .job_pop_o    (job_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .last_of_run_o(last_of_run_o),
    .curve_end_o  (curve_end_o)
  );

  // The end of a curve is always the last point of its run.
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && curve_end_o |-> last_of_run_o)
    else $error("curve_end without last_of_run");

  // The back end only retires a job that the queue actually holds.
  a_pop_has_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |-> job_valid)
    else $error("job popped from an empty queue");

  // The mode register changes only through a register write.
  a_mode_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_write |=> $stable(mode_q))
    else $error("scheme mode changed without a write");

endmodule
